// File: rtl/framed_command_receiver_defines.svh
// assertion macros shared by the receiver modules
`ifndef FRAMED_COMMAND_RECEIVER_DEFINES_SVH
`define FRAMED_COMMAND_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define FCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define FCR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define FCR_ASSERT(lbl, prop, msg)
`define FCR_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: rtl/fcr_pkg.sv
`default_nettype none

package fcr_pkg;

  // sizes
  localparam int PAYLOAD_CAPACITY = 16;
  localparam int IDX_W            = $clog2(PAYLOAD_CAPACITY);
  localparam int CNT_W            = 5;
  localparam int HDR_LEN          = 3;
  localparam int UPC_W            = 5;

  // register reset values
  localparam logic [7:0] HEADER_TIMEOUT_RST  = 8'd30;
  localparam logic [7:0] PAYLOAD_TIMEOUT_RST = 8'd50;
  localparam logic [2:0] MAX_TRIES_RST       = 3'd3;
  localparam logic [7:0] ACK_CODE_RST        = 8'd128;
  localparam logic [7:0] NACK_CODE_RST       = 8'd0;

  // configuration register indexes
  localparam logic [2:0] REG_HEADER_TIMEOUT  = 3'd0;
  localparam logic [2:0] REG_PAYLOAD_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_MAX_TRIES       = 3'd2;
  localparam logic [2:0] REG_ACK_CODE        = 3'd3;
  localparam logic [2:0] REG_NACK_CODE       = 3'd4;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_GATHER = 2'd1,
    PH_CHECK  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    KIND_REPLY   = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_DROP    = 3'd3,
    KIND_RESET   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_SIZE_ZERO,
    LAST_IDX_END
  } last_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_HUNT,
    OP_ATTEMPT_NEW,
    OP_ATTEMPT_RETRY,
    OP_TRY_INC,
    OP_TICK_DEC,
    OP_HDR_BYTE,
    OP_GATHER,
    OP_IDX_CLR,
    OP_IDX_INC,
    OP_RD_PAY
  } dp_op_e;

  typedef enum logic [2:0] {
    SEQ_WAIT,
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_BR,
    SEQ_DISPATCH,
    SEQ_DONE
  } seq_e;

  typedef enum logic {
    COND_SIZE_ZERO,
    COND_IDX_MORE
  } cond_e;

  // one control word of the program
  typedef struct packed {
    logic             emit;
    kind_e            kind;
    logic             nack;
    last_e            last;
    dp_op_e           op;
    seq_e             seq;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic   tick;
    logic   expired;
    phase_e phase;
    logic   hdr_full;
    logic   hdr_started;
    logic   sum_match;
    logic   size_over;
    logic   size_zero;
    logic   tries_out;
    logic   idx_more;
    logic   out_stall;
  } status_t;

  // program addresses
  localparam logic [UPC_W-1:0] A_IDLE       = 5'd0;
  localparam logic [UPC_W-1:0] A_DECODE     = 5'd1;
  localparam logic [UPC_W-1:0] A_TICK_DEC   = 5'd2;
  localparam logic [UPC_W-1:0] A_TICK_RESET = 5'd3;
  localparam logic [UPC_W-1:0] A_TICK_PART  = 5'd4;
  localparam logic [UPC_W-1:0] A_DROP       = 5'd5;
  localparam logic [UPC_W-1:0] A_HDR_BYTE   = 5'd6;
  localparam logic [UPC_W-1:0] A_HDR_NACK   = 5'd7;
  localparam logic [UPC_W-1:0] A_HDR_ACK    = 5'd8;
  localparam logic [UPC_W-1:0] A_ACK_FRAME  = 5'd9;
  localparam logic [UPC_W-1:0] A_FRM_HDR    = 5'd10;
  localparam logic [UPC_W-1:0] A_FRM_RD     = 5'd11;
  localparam logic [UPC_W-1:0] A_FRM_PAY    = 5'd12;
  localparam logic [UPC_W-1:0] A_FRM_END    = 5'd13;
  localparam logic [UPC_W-1:0] A_GATHER     = 5'd14;
  localparam logic [UPC_W-1:0] A_CHK_RETRY  = 5'd15;
  localparam logic [UPC_W-1:0] A_CHK_DROP   = 5'd16;
  localparam logic [UPC_W-1:0] A_LAST       = 5'd16;

  function automatic uword_t uw(logic emit, kind_e kind, logic nack, last_e last,
                                dp_op_e op, seq_e seq, cond_e cond,
                                logic [UPC_W-1:0] target);
    uword_t w;
    w.emit   = emit;
    w.kind   = kind;
    w.nack   = nack;
    w.last   = last;
    w.op     = op;
    w.seq    = seq;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // control store
  function automatic uword_t fcr_rom(logic [UPC_W-1:0] addr);
    uword_t w;
    case (addr)
      A_IDLE:       w = uw(1'b0, KIND_REPLY, 1'b0, LAST_NO, OP_NONE, SEQ_WAIT,
                           COND_SIZE_ZERO, A_IDLE);
      A_DECODE:     w = uw(1'b0, KIND_REPLY, 1'b0, LAST_NO, OP_NONE, SEQ_DISPATCH,
                           COND_SIZE_ZERO, A_IDLE);
      A_TICK_DEC:   w = uw(1'b0, KIND_REPLY, 1'b0, LAST_NO, OP_TICK_DEC, SEQ_DONE,
                           COND_SIZE_ZERO, A_IDLE);
      A_TICK_RESET: w = uw(1'b0, KIND_REPLY, 1'b0, LAST_NO, OP_HUNT, SEQ_DONE,
                           COND_SIZE_ZERO, A_IDLE);
      A_TICK_PART:  w = uw(1'b1, KIND_RESET, 1'b0, LAST_YES, OP_HUNT, SEQ_DONE,
                           COND_SIZE_ZERO, A_IDLE);
      A_DROP:       w = uw(1'b1, KIND_DROP, 1'b0, LAST_YES, OP_HUNT, SEQ_DONE,
                           COND_SIZE_ZERO, A_IDLE);
      A_HDR_BYTE:   w = uw(1'b0, KIND_REPLY, 1'b0, LAST_NO, OP_HDR_BYTE, SEQ_DONE,
                           COND_SIZE_ZERO, A_IDLE);
      A_HDR_NACK:   w = uw(1'b1, KIND_REPLY, 1'b1, LAST_YES, OP_HUNT, SEQ_DONE,
                           COND_SIZE_ZERO, A_IDLE);
      A_HDR_ACK:    w = uw(1'b1, KIND_REPLY, 1'b0, LAST_YES, OP_ATTEMPT_NEW, SEQ_DONE,
                           COND_SIZE_ZERO, A_IDLE);
      A_ACK_FRAME:  w = uw(1'b1, KIND_REPLY, 1'b0, LAST_NO, OP_NONE, SEQ_NEXT,
                           COND_SIZE_ZERO, A_IDLE);
      A_FRM_HDR:    w = uw(1'b1, KIND_HEADER, 1'b0, LAST_SIZE_ZERO, OP_IDX_CLR, SEQ_BR,
                           COND_SIZE_ZERO, A_FRM_END);
      A_FRM_RD:     w = uw(1'b0, KIND_REPLY, 1'b0, LAST_NO, OP_RD_PAY, SEQ_NEXT,
                           COND_SIZE_ZERO, A_IDLE);
      A_FRM_PAY:    w = uw(1'b1, KIND_PAYLOAD, 1'b0, LAST_IDX_END, OP_IDX_INC, SEQ_BR,
                           COND_IDX_MORE, A_FRM_RD);
      A_FRM_END:    w = uw(1'b0, KIND_REPLY, 1'b0, LAST_NO, OP_HUNT, SEQ_DONE,
                           COND_SIZE_ZERO, A_IDLE);
      A_GATHER:     w = uw(1'b0, KIND_REPLY, 1'b0, LAST_NO, OP_GATHER, SEQ_DONE,
                           COND_SIZE_ZERO, A_IDLE);
      A_CHK_RETRY:  w = uw(1'b1, KIND_REPLY, 1'b1, LAST_YES, OP_ATTEMPT_RETRY, SEQ_DONE,
                           COND_SIZE_ZERO, A_IDLE);
      A_CHK_DROP:   w = uw(1'b1, KIND_REPLY, 1'b1, LAST_NO, OP_TRY_INC, SEQ_JUMP,
                           COND_SIZE_ZERO, A_DROP);
      default:      w = uw(1'b0, KIND_REPLY, 1'b0, LAST_NO, OP_NONE, SEQ_DONE,
                           COND_SIZE_ZERO, A_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/framed_command_receiver.sv
`default_nettype none
// steps: a word passes accept, decode and an action step; nack then drop adds a drop step,
//   an accepted frame takes ack, header, then read and emit per payload byte, then an end step
// sequencing: the sequencer steps one control word per cycle and takes a new word only
//   back at its idle step; a held result register stalls the step that emits
// reset: asynchronous, clears the sequencer, frame state and result valid and loads
//   register reset values; header and payload stores are not cleared

module framed_command_receiver import fcr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             action_i,
  input  wire logic [7:0]       rx_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [2:0]            kind_o,
  output logic [7:0]            tx_byte_o,
  output logic [7:0]            group_id_o,
  output logic [7:0]            command_code_o,
  output logic [4:0]            payload_size_o,
  output logic [IDX_W-1:0]      payload_index_o,
  output logic [7:0]            payload_byte_o,
  output logic                  last_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [7:0]       cfg_data_i
);

  uword_t  ctrl;
  status_t status;
  logic    in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  // control sequencer
  fcr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  // datapath
  fcr_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_fire_i       (in_fire),
    .action_i        (action_i),
    .rx_byte_i       (rx_byte_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .tx_byte_o       (tx_byte_o),
    .group_id_o      (group_id_o),
    .command_code_o  (command_code_o),
    .payload_size_o  (payload_size_o),
    .payload_index_o (payload_index_o),
    .payload_byte_o  (payload_byte_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// File: rtl/fcr_seq.sv
`default_nettype none
`include "framed_command_receiver_defines.svh"

module fcr_seq import fcr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output uword_t       ctrl_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  logic [UPC_W-1:0] disp_addr;
  logic             advance;
  logic             cond_true;

  // current control word
  always_comb begin
    ctrl_o     = fcr_rom(upc_q);
    in_ready_o = (ctrl_o.seq == SEQ_WAIT);
  end

  // a word that emits waits while the result register holds a result not yet taken
  assign advance = !(ctrl_o.emit && status_i.out_stall);

  // dispatch on the latched word and the frame state
  always_comb begin
    disp_addr = A_TICK_DEC;
    if (status_i.tick) begin
      if (!status_i.expired) begin
        disp_addr = A_TICK_DEC;
      end else if (status_i.phase == PH_HUNT) begin
        disp_addr = status_i.hdr_started ? A_TICK_PART : A_TICK_RESET;
      end else begin
        disp_addr = A_DROP;
      end
    end else begin
      case (status_i.phase)
        PH_HUNT: begin
          if (!status_i.hdr_full) begin
            disp_addr = A_HDR_BYTE;
          end else if (!status_i.sum_match || status_i.size_over) begin
            disp_addr = A_HDR_NACK;
          end else if (status_i.size_zero) begin
            disp_addr = A_ACK_FRAME;
          end else begin
            disp_addr = A_HDR_ACK;
          end
        end
        PH_GATHER: disp_addr = A_GATHER;
        default: begin
          if (status_i.sum_match) begin
            disp_addr = A_ACK_FRAME;
          end else if (status_i.tries_out) begin
            disp_addr = A_CHK_DROP;
          end else begin
            disp_addr = A_CHK_RETRY;
          end
        end
      endcase
    end
  end

  // branch condition
  always_comb begin
    case (ctrl_o.cond)
      COND_SIZE_ZERO: cond_true = status_i.size_zero;
      COND_IDX_MORE:  cond_true = status_i.idx_more;
      default:        cond_true = 1'b0;
    endcase
  end

  // step counter
  always_comb begin
    upc_d = upc_q;
    if (advance) begin
      case (ctrl_o.seq)
        SEQ_WAIT:     upc_d = in_valid_i ? upc_q + 5'd1 : upc_q;
        SEQ_NEXT:     upc_d = upc_q + 5'd1;
        SEQ_JUMP:     upc_d = ctrl_o.target;
        SEQ_BR:       upc_d = cond_true ? ctrl_o.target : upc_q + 5'd1;
        SEQ_DISPATCH: upc_d = disp_addr;
        SEQ_DONE:     upc_d = A_IDLE;
        default:      upc_d = A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= A_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  `FCR_ASSERT(a_decode_after_accept, (in_valid_i && in_ready_o) |=> (upc_q == A_DECODE), "accepted word not decoded")
  `FCR_ASSERT_NEVER(a_upc_range, upc_q > A_LAST, "step counter left the program")

endmodule

`default_nettype wire

// File: rtl/fcr_dpath.sv
`default_nettype none
`include "framed_command_receiver_defines.svh"

module fcr_dpath import fcr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_fire_i,
  input  wire logic             action_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [7:0]       cfg_data_i,
  input  wire uword_t           ctrl_i,
  output status_t               status_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [2:0]            kind_o,
  output logic [7:0]            tx_byte_o,
  output logic [7:0]            group_id_o,
  output logic [7:0]            command_code_o,
  output logic [4:0]            payload_size_o,
  output logic [IDX_W-1:0]      payload_index_o,
  output logic [7:0]            payload_byte_o,
  output logic                  last_o
);

  // configuration
  logic [7:0] header_timeout_q, payload_timeout_q, ack_code_q, nack_code_q;
  logic [2:0] max_tries_q;

  // latched input word
  logic       action_q;
  logic [7:0] rx_q;

  // frame state
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       sum_q, sum_d;
  logic [2:0]       tries_q, tries_d;
  logic [7:0]       ticks_q, ticks_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       hdr_q [HDR_LEN];
  logic [7:0]       pay_mem [PAYLOAD_CAPACITY];
  logic [7:0]       rd_q;

  // result register
  logic             out_valid_q;
  logic [2:0]       kind_q;
  logic [7:0]       tx_q, grp_q, cmd_q, pbyte_q;
  logic [4:0]       size_q;
  logic [IDX_W-1:0] pidx_q;
  logic             last_q;

  logic       out_stall, advance, last_val;
  logic [2:0] tries_inc;
  logic [7:0] size;
  logic [7:0] idx_next;

  assign out_stall = out_valid_q && !out_ready_i;
  assign advance   = !(ctrl_i.emit && out_stall);
  assign tries_inc = tries_q + 3'd1;
  assign size      = hdr_q[2];
  assign idx_next  = 8'(idx_q) + 8'd1;

  // flags for dispatch and branches
  always_comb begin
    status_o.tick        = action_q;
    status_o.expired     = (ticks_q <= 8'd1);
    status_o.phase       = phase_q;
    status_o.hdr_full    = (count_q >= CNT_W'(HDR_LEN));
    status_o.hdr_started = (count_q != '0);
    status_o.sum_match   = (rx_q == sum_q);
    status_o.size_over   = (size > 8'(PAYLOAD_CAPACITY));
    status_o.size_zero   = (size == 8'd0);
    status_o.tries_out   = (tries_inc >= max_tries_q) || (tries_inc == 3'd0);
    status_o.idx_more    = (idx_next != size);
    status_o.out_stall   = out_stall;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_timeout_q  <= HEADER_TIMEOUT_RST;
      payload_timeout_q <= PAYLOAD_TIMEOUT_RST;
      max_tries_q       <= MAX_TRIES_RST;
      ack_code_q        <= ACK_CODE_RST;
      nack_code_q       <= NACK_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_HEADER_TIMEOUT:  header_timeout_q  <= cfg_data_i;
        REG_PAYLOAD_TIMEOUT: payload_timeout_q <= cfg_data_i;
        REG_MAX_TRIES:       max_tries_q       <= cfg_data_i[2:0];
        REG_ACK_CODE:        ack_code_q        <= cfg_data_i;
        REG_NACK_CODE:       nack_code_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      action_q <= action_i;
      rx_q     <= rx_byte_i;
    end
  end

  // frame state update
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    sum_d   = sum_q;
    tries_d = tries_q;
    ticks_d = ticks_q;
    idx_d   = idx_q;
    if (advance) begin
      case (ctrl_i.op)
        OP_HUNT: begin
          phase_d = PH_HUNT;
          count_d = '0;
          sum_d   = 8'd0;
          ticks_d = header_timeout_q;
        end
        OP_ATTEMPT_NEW, OP_ATTEMPT_RETRY: begin
          tries_d = (ctrl_i.op == OP_ATTEMPT_NEW) ? 3'd0 : tries_inc;
          phase_d = PH_GATHER;
          count_d = '0;
          sum_d   = 8'd0;
          ticks_d = payload_timeout_q;
        end
        OP_TRY_INC:  tries_d = tries_inc;
        OP_TICK_DEC: ticks_d = ticks_q - 8'd1;
        OP_HDR_BYTE: begin
          sum_d   = sum_q + rx_q;
          count_d = count_q + CNT_W'(1);
        end
        OP_GATHER: begin
          sum_d   = sum_q + rx_q;
          count_d = count_q + CNT_W'(1);
          ticks_d = payload_timeout_q;
          if ((8'(count_q) + 8'd1) >= size) begin
            phase_d = PH_CHECK;
          end
        end
        OP_IDX_CLR: idx_d = '0;
        OP_IDX_INC: idx_d = idx_q + IDX_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= '0;
      sum_q   <= 8'd0;
      tries_q <= 3'd0;
      ticks_q <= HEADER_TIMEOUT_RST;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      tries_q <= tries_d;
      ticks_q <= ticks_d;
      idx_q   <= idx_d;
    end
  end

  // header bytes
  always_ff @(posedge clk_i) begin
    if (advance && ctrl_i.op == OP_HDR_BYTE) begin
      hdr_q[count_q[1:0]] <= rx_q;
    end
  end

  // payload store, registered read
  always_ff @(posedge clk_i) begin
    if (advance && ctrl_i.op == OP_GATHER && count_q < CNT_W'(PAYLOAD_CAPACITY)) begin
      pay_mem[count_q[IDX_W-1:0]] <= rx_q;
    end
    if (advance && ctrl_i.op == OP_RD_PAY) begin
      rd_q <= pay_mem[idx_q];
    end
  end

  // last flag of the word being emitted
  always_comb begin
    case (ctrl_i.last)
      LAST_NO:        last_val = 1'b0;
      LAST_YES:       last_val = 1'b1;
      LAST_SIZE_ZERO: last_val = (size == 8'd0);
      LAST_IDX_END:   last_val = (idx_next == size);
      default:        last_val = 1'b0;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit && advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit && advance) begin
      kind_q  <= ctrl_i.kind;
      tx_q    <= (ctrl_i.kind != KIND_REPLY) ? 8'd0 :
                 (ctrl_i.nack ? nack_code_q : ack_code_q);
      grp_q   <= (ctrl_i.kind == KIND_HEADER) ? hdr_q[0] : 8'd0;
      cmd_q   <= (ctrl_i.kind == KIND_HEADER) ? hdr_q[1] : 8'd0;
      size_q  <= (ctrl_i.kind == KIND_HEADER) ? size[4:0] : 5'd0;
      pidx_q  <= (ctrl_i.kind == KIND_PAYLOAD) ? idx_q : '0;
      pbyte_q <= (ctrl_i.kind == KIND_PAYLOAD) ? rd_q : 8'd0;
      last_q  <= last_val;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign tx_byte_o       = tx_q;
  assign group_id_o      = grp_q;
  assign command_code_o  = cmd_q;
  assign payload_size_o  = size_q;
  assign payload_index_o = pidx_q;
  assign payload_byte_o  = pbyte_q;
  assign last_o          = last_q;

  `FCR_ASSERT_NEVER(a_count_range, count_q > CNT_W'(PAYLOAD_CAPACITY), "byte count beyond capacity")
  `FCR_ASSERT(a_size_in_payload, (phase_q != PH_HUNT) |-> (size != 8'd0 && size <= 8'(PAYLOAD_CAPACITY)), "payload phase with bad size")
  `FCR_ASSERT(a_pay_index, (advance && ctrl_i.emit && ctrl_i.kind == KIND_PAYLOAD) |-> (8'(idx_q) < size), "payload index beyond size")

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import fcr_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 500;

  // one result of the receiver, at the port widths
  typedef struct packed {
    kind_e            kind;
    logic [7:0]       tx;
    logic [7:0]       grp;
    logic [7:0]       cmd;
    logic [4:0]       psize;
    logic [IDX_W-1:0] pos;
    logic [7:0]       pbyte;
    logic             last;
  } rx_result_t;

  // one row of the directed table; known rows carry their single result typed in
  typedef struct packed {
    logic       tick;
    logic [7:0] b;
    logic       known;
    kind_e      kind;
    logic [7:0] tx;
  } stim_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             action_i    = 1'b0;
  logic [7:0]       rx_byte_i   = 8'h00;
  logic             out_ready_i = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [2:0]       cfg_index_i = REG_HEADER_TIMEOUT;
  logic [7:0]       cfg_data_i  = 8'h00;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [2:0]       kind_o;
  logic [7:0]       tx_byte_o;
  logic [7:0]       group_id_o;
  logic [7:0]       command_code_o;
  logic [4:0]       payload_size_o;
  logic [IDX_W-1:0] payload_index_o;
  logic [7:0]       payload_byte_o;
  logic             last_o;

  // run bookkeeping
  bit          calm = 1'b0;
  int unsigned fail_count;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned frames_taken;
  int unsigned frames_dropped;
  int unsigned headers_cleared;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  rx_result_t results_due [$];
  rx_result_t word_out [$];
  stim_row_t  directed [$];

  // predictor copy of registers and frame state
  logic [7:0] p_hdr_timeout;
  logic [7:0] p_pay_timeout;
  logic [2:0] p_max_tries;
  logic [7:0] p_ack;
  logic [7:0] p_nack;
  phase_e     p_phase;
  logic [4:0] p_count;
  logic [7:0] p_hdr [HDR_LEN];
  logic [7:0] p_sum;
  logic [2:0] p_tries;
  logic [7:0] p_ticks;
  logic [7:0] p_pay [PAYLOAD_CAPACITY];

  framed_command_receiver i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .tx_byte_o       (tx_byte_o),
    .group_id_o      (group_id_o),
    .command_code_o  (command_code_o),
    .payload_size_o  (payload_size_o),
    .payload_index_o (payload_index_o),
    .payload_byte_o  (payload_byte_o),
    .last_o          (last_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void add_result(kind_e k, logic [7:0] tx, logic [7:0] grp,
                                     logic [7:0] cmd, logic [4:0] sz,
                                     logic [IDX_W-1:0] pos, logic [7:0] pb);
    rx_result_t r;
    r.kind  = k;
    r.tx    = tx;
    r.grp   = grp;
    r.cmd   = cmd;
    r.psize = sz;
    r.pos   = pos;
    r.pbyte = pb;
    r.last  = 1'b0;
    word_out.push_back(r);
  endfunction

  function automatic void restart_hunt();
    p_phase = PH_HUNT;
    p_count = '0;
    p_sum   = '0;
    p_ticks = p_hdr_timeout;
  endfunction

  function automatic void restart_attempt();
    p_phase = PH_GATHER;
    p_count = '0;
    p_sum   = '0;
    p_ticks = p_pay_timeout;
  endfunction

  // accepted frame: header result, then one result per payload byte
  function automatic void emit_frame();
    add_result(KIND_HEADER, 8'h00, p_hdr[0], p_hdr[1], p_hdr[2][4:0], '0, 8'h00);
    for (int i = 0; i < p_hdr[2] && i < PAYLOAD_CAPACITY; i++)
      add_result(KIND_PAYLOAD, 8'h00, 8'h00, 8'h00, 5'd0, IDX_W'(i), p_pay[IDX_W'(i)]);
    restart_hunt();
  endfunction

  // results caused by one word, left in word_out
  function automatic void predict_word(logic tick, logic [7:0] b);
    word_out.delete();
    if (tick) begin
      if (p_ticks > 8'd1) begin
        p_ticks--;
      end else begin
        if (p_phase != PH_HUNT)
          add_result(KIND_DROP, 8'h00, 8'h00, 8'h00, 5'd0, '0, 8'h00);
        else if (p_count != 0)
          add_result(KIND_RESET, 8'h00, 8'h00, 8'h00, 5'd0, '0, 8'h00);
        restart_hunt();
      end
    end else if (p_phase == PH_HUNT) begin
      if (p_count < HDR_LEN) begin
        p_hdr[p_count[1:0]] = b;
        p_sum               = p_sum + b;
        p_count++;
      end else if (b != p_sum || p_hdr[2] > PAYLOAD_CAPACITY) begin
        add_result(KIND_REPLY, p_nack, 8'h00, 8'h00, 5'd0, '0, 8'h00);
        restart_hunt();
      end else begin
        add_result(KIND_REPLY, p_ack, 8'h00, 8'h00, 5'd0, '0, 8'h00);
        if (p_hdr[2] == 8'd0) begin
          emit_frame();
        end else begin
          p_tries = '0;
          restart_attempt();
        end
      end
    end else if (p_phase == PH_GATHER) begin
      if (p_count < PAYLOAD_CAPACITY)
        p_pay[p_count[IDX_W-1:0]] = b;
      p_sum   = p_sum + b;
      p_count++;
      p_ticks = p_pay_timeout;
      if (p_count >= p_hdr[2])
        p_phase = PH_CHECK;
    end else if (b == p_sum) begin
      add_result(KIND_REPLY, p_ack, 8'h00, 8'h00, 5'd0, '0, 8'h00);
      emit_frame();
    end else begin
      // failed attempt: retry or give up once the tries run out
      add_result(KIND_REPLY, p_nack, 8'h00, 8'h00, 5'd0, '0, 8'h00);
      p_tries++;
      if (p_tries >= p_max_tries || p_tries == 3'd0) begin
        add_result(KIND_DROP, 8'h00, 8'h00, 8'h00, 5'd0, '0, 8'h00);
        restart_hunt();
      end else begin
        restart_attempt();
      end
    end
    if (word_out.size() != 0)
      word_out[word_out.size() - 1].last = 1'b1;
  endfunction

  function automatic stim_row_t row_word(logic tick, logic [7:0] b);
    stim_row_t r;
    r.tick  = tick;
    r.b     = b;
    r.known = 1'b0;
    r.kind  = KIND_REPLY;
    r.tx    = 8'h00;
    return r;
  endfunction

  function automatic stim_row_t row_known(logic tick, logic [7:0] b, kind_e k,
                                          logic [7:0] tx);
    stim_row_t r;
    r = row_word(tick, b);
    r.known = 1'b1;
    r.kind  = k;
    r.tx    = tx;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // one word over the input channel, with an occasional gap in front
  task automatic send_word(logic tick, logic [7:0] b, logic known = 1'b0,
                           kind_e k = KIND_REPLY, logic [7:0] tx = 8'h00);
    rx_result_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= tick;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    predict_word(tick, b);
    if (known) begin
      r       = '0;
      r.kind  = k;
      r.tx    = tx;
      r.last  = 1'b1;
      results_due.push_back(r);
    end else begin
      foreach (word_out[i]) results_due.push_back(word_out[i]);
    end
  endtask

  // byte that may be preceded by an idle tick
  task automatic send_byte(logic [7:0] b);
    if ($urandom_range(0, 19) == 0)
      send_word(1'b1, 8'($urandom));
    send_word(1'b0, b);
  endtask

  // hold the sender until every result is in and the block is idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_HEADER_TIMEOUT:  p_hdr_timeout = val;
      REG_PAYLOAD_TIMEOUT: p_pay_timeout = val;
      REG_MAX_TRIES:       p_max_tries   = val[2:0];
      REG_ACK_CODE:        p_ack         = val;
      REG_NACK_CODE:       p_nack        = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [7:0] ht, logic [7:0] pt, logic [7:0] mt,
                          logic [7:0] ack, logic [7:0] nack);
    settle();
    write_reg(REG_HEADER_TIMEOUT, ht);
    write_reg(REG_PAYLOAD_TIMEOUT, pt);
    write_reg(REG_MAX_TRIES, mt);
    write_reg(REG_ACK_CODE, ack);
    write_reg(REG_NACK_CODE, nack);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_regs();
    logic [7:0] ht;
    logic [7:0] pt;
    logic [7:0] mt;
    ht = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
    pt = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
    mt = (8'($urandom) & 8'hF8) | 8'($urandom_range(0, 7));
    set_regs(ht, pt, mt, 8'($urandom), 8'($urandom));
  endtask

  // well-formed frame with random content, a few broken on purpose
  task automatic send_frame();
    logic [7:0]  grp;
    logic [7:0]  cmd;
    logic [7:0]  sz;
    logic [7:0]  hsum;
    logic [7:0]  psum;
    logic [7:0]  pb;
    logic        hdr_good;
    logic        good;
    int unsigned attempts;
    // bring the block back to an empty header hunt first
    while (p_phase != PH_HUNT || p_count != 0) begin
      if (p_phase == PH_GATHER || (p_phase == PH_HUNT && p_count < HDR_LEN))
        send_word(1'b0, 8'($urandom));
      else
        send_word(1'b0, p_sum + 8'd1);
    end
    grp = 8'($urandom);
    cmd = 8'($urandom);
    case ($urandom_range(0, 15))
      0:       sz = 8'd0;
      1:       sz = 8'(PAYLOAD_CAPACITY);
      2:       sz = 8'($urandom_range(PAYLOAD_CAPACITY + 1, 255));
      default: sz = 8'($urandom_range(1, 4));
    endcase
    hsum     = grp + cmd + sz;
    hdr_good = $urandom_range(0, 7) != 0;
    send_byte(grp);
    send_byte(cmd);
    send_byte(sz);
    send_byte(hdr_good ? hsum : hsum ^ (8'd1 << $urandom_range(0, 7)));
    if (!hdr_good || sz == 8'd0 || sz > PAYLOAD_CAPACITY)
      return;
    attempts = $urandom_range(1, 3);
    for (int t = 1; t <= attempts; t++) begin
      psum = 8'h00;
      for (int i = 0; i < sz; i++) begin
        pb   = 8'($urandom);
        psum = psum + pb;
        send_byte(pb);
      end
      good = (t == attempts) && ($urandom_range(0, 3) != 0);
      send_byte(good ? psum : psum + 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic run_phase(int unsigned words);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < words) begin
      case ($urandom_range(0, 9))
        0:       repeat ($urandom_range(1, 6)) send_word(1'b1, 8'($urandom));
        1:       send_word(1'b0, 8'($urandom));
        default: send_frame();
      endcase
    end
  endtask

  // receiver stalls in bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 12);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    rx_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (kind_o == KIND_HEADER) frames_taken++;
      if (kind_o == KIND_DROP) frames_dropped++;
      if (kind_o == KIND_RESET) headers_cleared++;
      if (results_due.size() == 0) begin
        $error("result with nothing expected: kind %0d", kind_o);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("tx_byte", want.tx, tx_byte_o);
        check_field("group_id", want.grp, group_id_o);
        check_field("command_code", want.cmd, command_code_o);
        check_field("payload_size", want.psize, payload_size_o);
        check_field("payload_index", want.pos, payload_index_o);
        check_field("payload_byte", want.pbyte, payload_byte_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // watchdog on cycles where no word moves on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    p_hdr_timeout = HEADER_TIMEOUT_RST;
    p_pay_timeout = PAYLOAD_TIMEOUT_RST;
    p_max_tries   = MAX_TRIES_RST;
    p_ack         = ACK_CODE_RST;
    p_nack        = NACK_CODE_RST;
    p_tries       = '0;
    restart_hunt();

    // bad header check byte
    directed.push_back(row_word(1'b0, 8'h00));
    directed.push_back(row_word(1'b0, 8'h00));
    directed.push_back(row_word(1'b0, 8'h00));
    directed.push_back(row_known(1'b0, 8'h01, KIND_REPLY, NACK_CODE_RST));
    // empty payload, group and command at their top values
    directed.push_back(row_word(1'b0, 8'hFF));
    directed.push_back(row_word(1'b0, 8'hFF));
    directed.push_back(row_word(1'b0, 8'h00));
    directed.push_back(row_word(1'b0, 8'hFE));
    // size one above capacity
    directed.push_back(row_word(1'b0, 8'h00));
    directed.push_back(row_word(1'b0, 8'h00));
    directed.push_back(row_word(1'b0, 8'h11));
    directed.push_back(row_known(1'b0, 8'h11, KIND_REPLY, NACK_CODE_RST));
    // header timeout, first with nothing collected, then with one byte
    directed.push_back(row_word(1'b1, 8'hA5));
    directed.push_back(row_word(1'b0, 8'h55));
    directed.push_back(row_known(1'b1, 8'h5A, KIND_RESET, 8'h00));
    // payload timeout at zero register value
    directed.push_back(row_word(1'b0, 8'h01));
    directed.push_back(row_word(1'b0, 8'h02));
    directed.push_back(row_word(1'b0, 8'h01));
    directed.push_back(row_known(1'b0, 8'h04, KIND_REPLY, ACK_CODE_RST));
    directed.push_back(row_known(1'b1, 8'h00, KIND_DROP, 8'h00));
    // bad payload check with max_tries of zero: nack then drop
    directed.push_back(row_word(1'b0, 8'h01));
    directed.push_back(row_word(1'b0, 8'h02));
    directed.push_back(row_word(1'b0, 8'h01));
    directed.push_back(row_known(1'b0, 8'h04, KIND_REPLY, ACK_CODE_RST));
    directed.push_back(row_word(1'b0, 8'hFF));
    directed.push_back(row_word(1'b0, 8'h00));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: header timeout at one, payload timeout and tries at zero, reply codes at reset values
    set_regs(8'd1, 8'd0, 8'd0, ACK_CODE_RST, NACK_CODE_RST);
    foreach (directed[i])
      send_word(directed[i].tick, directed[i].b, directed[i].known,
                directed[i].kind, directed[i].tx);

    // top extremes, nack code at zero
    set_regs(8'hFF, 8'hFF, 8'd7, 8'hFF, 8'h00);
    run_phase(15);
    // zero extremes, nack code at its top; upper data bits fall outside max_tries
    set_regs(8'h00, 8'h00, 8'hF8, 8'h00, 8'hFF);
    run_phase(15);
    repeat (3) begin
      random_regs();
      calm = $urandom_range(0, 3) == 0;
      run_phase(15);
    end
    // last stretch without idling on either side
    random_regs();
    calm = 1'b1;
    run_phase(15);

    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d words and %0d results over seven register settings",
             words_sent, results_seen);
    $display("%0d frames taken, %0d frames dropped, %0d partial headers cleared",
             frames_taken, frames_dropped, headers_cleared);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/fcr_pkg.sv
rtl/fcr_seq.sv
rtl/fcr_dpath.sv
rtl/framed_command_receiver.sv
tb/tb.sv
